@@ design/sha_pkg.sv @@
package sha_pkg;

  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned COUNT_W = 61;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428A2F98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hB5C0FBCF;
      6'd3:  r = 32'hE9B5DBA5; 6'd4:  r = 32'h3956C25B; 6'd5:  r = 32'h59F111F1;
      6'd6:  r = 32'h923F82A4; 6'd7:  r = 32'hAB1C5ED5; 6'd8:  r = 32'hD807AA98;
      6'd9:  r = 32'h12835B01; 6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE; 6'd14: r = 32'h9BDC06A7;
      6'd15: r = 32'hC19BF174; 6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC; 6'd20: r = 32'h2DE92C6F;
      6'd21: r = 32'h4A7484AA; 6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D; 6'd26: r = 32'hB00327C8;
      6'd27: r = 32'hBF597FC7; 6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27B70A85;
      6'd33: r = 32'h2E1B2138; 6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB; 6'd38: r = 32'h81C2C92E;
      6'd39: r = 32'h92722C85; 6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3; 6'd44: r = 32'hD192E819;
      6'd45: r = 32'hD6990624; 6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08; 6'd50: r = 32'h2748774C;
      6'd51: r = 32'h34B0BCB5; 6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3; 6'd56: r = 32'h748F82EE;
      6'd57: r = 32'h78A5636F; 6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB; 6'd62: r = 32'hBEF9A3F7;
      default: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

endpackage

@@ design/sha_fifo.sv @@
module sha_fifo import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output in_item_t head_item
);

  in_item_t   mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_r] <= push_item;
        wr_r        <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ design/sha_core.sv @@
module sha_core import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD2,
    ST_EMIT
  } state_t;

  state_t             state_r, ret_r;
  logic [31:0]        h_r [8];
  logic [31:0]        v_r [8];
  logic [31:0]        w_r [16];
  logic [COUNT_W-1:0] cnt_r;
  logic [63:0]        len_r;
  logic [5:0]         t_r;
  logic [2:0]         idx_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] s1e, ch, s0a, maj, t1, t2, w_new;
  logic        out_free;

  assign pos      = cnt_r[5:0];
  assign wi       = pos[5:2];
  assign sh       = {~pos[1:0], 3'b000};
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    s1e = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch  = v_r[6] ^ (v_r[4] & (v_r[5] ^ v_r[6]));
    s0a = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) | (v_r[2] & (v_r[0] | v_r[1]));
    t1  = v_r[7] + s1e + ch + round_k(t_r) + w_r[0];
    t2  = s0a + maj;
    w_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
          + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      t_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_RESTART: begin
                cnt_r <= '0;
                for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
              end
              KIND_BYTE: begin
                w_r[wi][sh +: 8] <= q_item.data_byte;
                cnt_r <= cnt_r + 1'b1;
                if (pos == 6'd63) begin
                  for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
                  t_r     <= '0;
                  ret_r   <= ST_IDLE;
                  state_r <= ST_ROUND;
                end
              end
              KIND_FINISH: begin
                len_r <= {cnt_r, 3'b000};
                // pad byte at the fill point, zeros behind it
                for (int j = 0; j < 64; j++) begin
                  if (6'(j) == pos) w_r[j/4][8*(3-(j%4)) +: 8] <= PAD_BYTE;
                  else if (6'(j) > pos) w_r[j/4][8*(3-(j%4)) +: 8] <= 8'h00;
                end
                if (pos < 6'd56) begin
                  w_r[14] <= cnt_r[60:29];
                  w_r[15] <= {cnt_r[28:0], 3'b000};
                  ret_r   <= ST_EMIT;
                end else begin
                  ret_r   <= ST_PAD2;
                end
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
                t_r     <= '0;
                idx_r   <= '0;
                state_r <= ST_ROUND;
              end
              default: ;
            endcase
          end
        end
        ST_ROUND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          t_r <= t_r + 1'b1;
          if (t_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          state_r <= ret_r;
        end
        ST_PAD2: begin
          for (int i = 0; i < 14; i++) w_r[i] <= '0;
          w_r[14] <= len_r[63:32];
          w_r[15] <= len_r[31:0];
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          t_r     <= '0;
          ret_r   <= ST_EMIT;
          state_r <= ST_ROUND;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_r.digest_word <= h_r[idx_r];
            out_r.word_index  <= idx_r;
            out_r.last_word   <= (idx_r == 3'd7);
            out_valid_r       <= 1'b1;
            idx_r             <= idx_r + 1'b1;
            if (idx_r == 3'd7) begin
              cnt_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/sha256_message_hasher.sv @@
// channel  ports                          payload
// input    in_valid, in_stall, in_item    kind, data_byte
// output   out_valid, out_stall, out_item digest_word, word_index, last_word
//
// The 64th byte of a block starts the compression, one round per cycle in
// the ROUND state, followed by the hash update in the ADD state.
// A finish compresses one or two padded blocks and then loads the eight
// digest words, one at a time, into the output register.
// A two-entry input queue keeps taking items while the core compresses, until it is full.
// Reset (rst_n low, synchronous) loads the initial hash values and empties
// the queue; out_stall holds the current digest word and pauses emission.
module sha256_message_hasher import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     q_full, q_valid, q_pop;
  in_item_t q_item;

  sha_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (q_item)
  );

  assign in_stall = q_full;

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last_word disagrees with word_index");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_item.last_word) ##1 out_valid
      |-> out_item.word_index == $past(out_item.word_index) + 3'd1)
    else $error("digest words out of order");

endmodule

@@ sim/testbench.sv @@
module testbench;
  import sha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  sha256_message_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  localparam int IDLE_LIMIT = 20000;

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_bytes;

  in_item_t  pending_items [$];
  out_item_t digest_queue [$];
  int        error_count;
  int        idle_cycles;
  bit        stim_done;
  int        send_gap;
  int        recv_gap;
  int        hold_off;
  int        hold_trigger;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, wt;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s1 = ror32(w[(t-2)%16], 17) ^ ror32(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
        s0 = ror32(w[(t-15)%16], 7) ^ ror32(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
        wt = s1 + w[(t-7)%16] + s0 + w[t%16];
        w[t%16] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + K_TABLE[t] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
    msg_bytes = '0;
  endtask

  task automatic predict_digest(in_item_t it);
    int pos;
    logic [63:0] bit_len;
    out_item_t o;
    pos = int'(msg_bytes[5:0]);
    case (kind_t'(it.kind))
      KIND_RESTART: restart_digest();
      KIND_BYTE: begin
        msg_block[pos] = it.data_byte;
        msg_bytes = msg_bytes + 1'b1;
        if (pos == 63) compress_block();
      end
      KIND_FINISH: begin
        bit_len = {msg_bytes, 3'b000};
        msg_block[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
          while (pos < 64) msg_block[pos++] = 8'h00;
          compress_block();
          pos = 0;
        end
        while (pos < 56) msg_block[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
          o.digest_word = hash_state[i];
          o.word_index = 3'(i);
          o.last_word = (i == 7);
          digest_queue.push_back(o);
        end
        restart_digest();
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(kind_t k, logic [7:0] b);
    in_item_t it;
    it.kind = k;
    it.data_byte = b;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_digest(in_item);
      if (send_gap > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end
    end
  end

  // monitor with receiver stall
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
      hold_off <= 0;
      hold_trigger <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, out_item);
          error_count++;
        end else begin
          exp_item = digest_queue.pop_front();
          if (out_item.digest_word !== exp_item.digest_word)
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_item.digest_word, out_item.digest_word);
          if (out_item.word_index !== exp_item.word_index)
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_item.word_index, out_item.word_index);
          if (out_item.last_word !== exp_item.last_word)
            $display("%0t: last_word expected %b actual %b", $time,
                     exp_item.last_word, out_item.last_word);
          if (out_item !== exp_item) error_count++;
        end
      end
      // one long hold-off while the sender keeps offering
      if (hold_trigger == 0 && out_valid) begin
        hold_trigger <= 1;
        hold_off <= 600;
        out_stall <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= (hold_off > 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        recv_gap <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int r;
    error_count = 0;
    stim_done = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    restart_digest();
    // empty message, "abc", extremes, unused kind, restart mid-message
    pending_items.push_back(make_item(KIND_FINISH, 8'h00));
    pending_items.push_back(make_item(KIND_BYTE, 8'h61));
    pending_items.push_back(make_item(KIND_BYTE, 8'h62));
    pending_items.push_back(make_item(KIND_BYTE, 8'h63));
    pending_items.push_back(make_item(KIND_UNUSED, 8'hFF));
    pending_items.push_back(make_item(KIND_FINISH, 8'hFF));
    pending_items.push_back(make_item(KIND_BYTE, 8'hFF));
    pending_items.push_back(make_item(KIND_BYTE, 8'h00));
    pending_items.push_back(make_item(KIND_RESTART, 8'hAA));
    pending_items.push_back(make_item(KIND_BYTE, 8'h55));
    pending_items.push_back(make_item(KIND_FINISH, 8'h00));
    // padding that spills into a second block, an exact full block, then padding that just fits
    for (int i = 0; i < 56; i++) pending_items.push_back(make_item(KIND_BYTE, 8'(i)));
    pending_items.push_back(make_item(KIND_FINISH, 8'h00));
    for (int i = 0; i < 64; i++) pending_items.push_back(make_item(KIND_BYTE, 8'(~i)));
    pending_items.push_back(make_item(KIND_FINISH, 8'h00));
    for (int i = 0; i < 55; i++) pending_items.push_back(make_item(KIND_BYTE, 8'hA5));
    pending_items.push_back(make_item(KIND_FINISH, 8'h00));
    // random messages, mostly short, with occasional noise
    n = 0;
    while (n < 100) begin
      int len;
      r = $urandom_range(0, 9);
      len = (r < 6) ? $urandom_range(0, 20) : $urandom_range(50, 130);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 39);
        if (r == 0) pending_items.push_back(make_item(KIND_UNUSED, 8'($urandom)));
        else if (r == 1) pending_items.push_back(make_item(KIND_RESTART, 8'($urandom)));
        else pending_items.push_back(make_item(KIND_BYTE, 8'($urandom)));
        n++;
      end
      pending_items.push_back(make_item(KIND_FINISH, 8'($urandom)));
      n++;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
